// File: rtl/upst_pkg.sv
// Package for the UDP port slot table: sizes, request and status codes,
// configuration indexes and the controller state type.
// Used by rtl/udp_port_slot_table.sv; depends on nothing.
package upst_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int PORT_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int ENTRY_W = PORT_W + ADDR_W;
    localparam int SLOTF_W = 6;
    localparam int CFG_W   = 32;

    localparam logic [PORT_W-1:0] AUTO_BASE_RST  = 16'd1024;
    localparam logic [PORT_W-1:0] AUTO_MASK_RST  = 16'd65472;
    localparam logic [ADDR_W-1:0] BCAST_ADDR_RST = 32'd0;
    localparam logic [ADDR_W-1:0] LOCAL_ADDR_RST = 32'd0;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_BIND    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_FULL       = 2'd1,
        STS_AUTO_RANGE = 2'd2,
        STS_NO_MATCH   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_AUTO_BASE  = 2'd0,
        CFG_AUTO_MASK  = 2'd1,
        CFG_BCAST_ADDR = 2'd2,
        CFG_LOCAL_ADDR = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_UPDATE,
        ST_LOOK,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/udp_port_slot_table.sv
// UDP port slot table: allocate, bind, release and lookup of socket slots.
// Depends on rtl/upst_pkg.sv and instances rtl/upst_ram.sv.
//
// The block takes one request at a time and gives one response for each.
// Bind and release check and update the requested slot, then respond. Allocate
// walks the in-use flags one slot per cycle and stops at the lowest free slot,
// or responds without a scan when the table is full. Lookup reads the port and
// address RAM through its single read port, one slot per cycle, and stops
// at the first matching slot, or after the last slot when nothing matches. A new
// request is taken while a response still waits in the output register.
// Configuration writes take effect at once and are meant for idle periods.
module udp_port_slot_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [upst_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [upst_pkg::SLOTF_W-1:0]  slot,
    input  logic [upst_pkg::PORT_W-1:0]   port,
    input  logic [upst_pkg::ADDR_W-1:0]   addr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [upst_pkg::SLOTF_W-1:0]  slot_out,
    output logic [upst_pkg::PORT_W-1:0]   port_out
);

    import upst_pkg::*;

    state_t              state_reg, state_next;
    logic [SLOTS-1:0]    in_use_reg, in_use_next;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]   chk_idx_reg, chk_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic [PORT_W-1:0]   cfg_base_reg, cfg_mask_reg;
    logic [ADDR_W-1:0]   cfg_bcast_reg, cfg_local_reg;

    op_t                 req_op_reg;
    logic [SLOTF_W-1:0]  req_slot_reg;
    logic [PORT_W-1:0]   req_port_reg;
    logic [ADDR_W-1:0]   req_addr_reg;

    status_t             res_status_reg, res_status_next;
    logic [SLOTF_W-1:0]  res_slot_reg, res_slot_next;
    logic [PORT_W-1:0]   res_port_reg, res_port_next;

    logic [1:0]          status_reg;
    logic [SLOTF_W-1:0]  slot_out_reg;
    logic [PORT_W-1:0]   port_out_reg;
    logic                out_load;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [PORT_W-1:0]   rd_port;
    logic [ADDR_W-1:0]   rd_addr;

    logic                in_accept;
    logic [SLOT_W-1:0]   req_idx;
    logic                req_in_range;
    logic                req_slot_used;
    logic                req_auto_range;
    logic [PORT_W-1:0]   bind_port;
    logic                look_hit;

    upst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_port = ram_rdata[ENTRY_W-1:ADDR_W];
    assign rd_addr = ram_rdata[ADDR_W-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign port_out  = port_out_reg;

    assign req_idx        = SLOT_W'(req_slot_reg);
    assign req_in_range   = (32'(req_slot_reg) < SLOTS);
    assign req_slot_used  = req_in_range && in_use_reg[req_idx];
    assign req_auto_range = ((req_port_reg & cfg_mask_reg) == cfg_base_reg);
    assign bind_port      = (req_port_reg == '0) ? (PORT_W'(req_idx) + cfg_base_reg)
                                                 : req_port_reg;
    assign look_hit = chk_valid_reg && in_use_reg[chk_idx_reg] && (rd_port == req_port_reg)
                      && ((rd_addr == '0) || (rd_addr == req_addr_reg));

    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        free_count_next = free_count_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_port_next   = res_port_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {PORT_W'(idx_reg) + cfg_base_reg, ADDR_W'(0)};
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_accept)
                begin
                    unique case (op_t'(op))
                        OP_ALLOC:   state_next = ST_ALLOC;
                        OP_LOOKUP:  state_next = ST_LOOK;
                        OP_BIND,
                        OP_RELEASE: state_next = ST_UPDATE;
                    endcase
                end
            end

            ST_ALLOC:
            begin
                res_slot_next = '0;
                res_port_next = '0;
                if (free_count_reg == '0)
                begin
                    res_status_next = STS_FULL;
                    state_next      = ST_EMIT;
                end
                else if (!in_use_reg[idx_reg])
                begin
                    ram_we               = 1'b1;
                    in_use_next[idx_reg] = 1'b1;
                    free_count_next      = free_count_reg - CNT_W'(1);
                    res_status_next      = STS_OK;
                    res_slot_next        = SLOTF_W'(idx_reg);
                    res_port_next        = PORT_W'(idx_reg) + cfg_base_reg;
                    state_next           = ST_EMIT;
                end
                else if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    res_status_next = STS_FULL;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            ST_UPDATE:
            begin
                res_slot_next = req_slot_reg;
                res_port_next = '0;
                state_next    = ST_EMIT;
                if (req_op_reg == OP_BIND && req_auto_range)
                begin
                    res_status_next = STS_AUTO_RANGE;
                end
                else if (!req_slot_used)
                begin
                    res_status_next = STS_NO_MATCH;
                end
                else if (req_op_reg == OP_BIND)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = req_idx;
                    ram_wdata       = {bind_port, req_addr_reg};
                    res_status_next = STS_OK;
                    res_port_next   = bind_port;
                end
                else
                begin
                    in_use_next[req_idx] = 1'b0;
                    free_count_next      = free_count_reg + CNT_W'(1);
                    res_status_next      = STS_OK;
                end
            end

            ST_LOOK:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                if (idx_reg != SLOT_W'(SLOTS - 1))
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
                res_port_next = '0;
                if (look_hit)
                begin
                    res_status_next = STS_OK;
                    res_slot_next   = SLOTF_W'(chk_idx_reg);
                    state_next      = ST_EMIT;
                end
                else if (chk_valid_reg && chk_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    res_status_next = STS_NO_MATCH;
                    res_slot_next   = '0;
                    state_next      = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_use_reg     <= '0;
            free_count_reg <= CNT_W'(SLOTS);
            idx_reg        <= '0;
            chk_idx_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            cfg_base_reg   <= AUTO_BASE_RST;
            cfg_mask_reg   <= AUTO_MASK_RST;
            cfg_bcast_reg  <= BCAST_ADDR_RST;
            cfg_local_reg  <= LOCAL_ADDR_RST;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            free_count_reg <= free_count_next;
            idx_reg        <= idx_next;
            chk_idx_reg    <= chk_idx_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_AUTO_BASE:  cfg_base_reg  <= cfg_data[PORT_W-1:0];
                    CFG_AUTO_MASK:  cfg_mask_reg  <= cfg_data[PORT_W-1:0];
                    CFG_BCAST_ADDR: cfg_bcast_reg <= cfg_data[ADDR_W-1:0];
                    CFG_LOCAL_ADDR: cfg_local_reg <= cfg_data[ADDR_W-1:0];
                endcase
            end
        end
    end

    // For a lookup, the broadcast address is mapped to the local address when the
    // request is taken.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_op_reg   <= op_t'(op);
            req_slot_reg <= slot;
            req_port_reg <= port;
            req_addr_reg <= (op_t'(op) == OP_LOOKUP && addr == cfg_bcast_reg) ? cfg_local_reg
                                                                               : addr;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_port_reg   <= res_port_next;
        if (out_load)
        begin
            status_reg   <= res_status_reg;
            slot_out_reg <= res_slot_reg;
            port_out_reg <= res_port_reg;
        end
    end

`ifndef SYNTHESIS
    a_free_count_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(free_count_reg) + $countones(in_use_reg)) == SLOTS)
        else $error("free count disagrees with in-use flags");

    a_response_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("response raised outside the emit state");

    a_lookup_hit_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && req_op_reg == OP_LOOKUP && status_reg == STS_OK)
        |-> in_use_reg[SLOT_W'(slot_out_reg)])
        else $error("lookup returned a free slot");

    a_ram_write_when_updating: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_ALLOC || state_reg == ST_UPDATE))
        else $error("entry RAM written during a scan or while idle");
`endif

endmodule

// File: rtl/upst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; instanced by rtl/udp_port_slot_table.sv.
module upst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
